FILE: hdl/pvp_pkg.sv
// Shared types, register codes, constants and helper functions of the pseudo-Voigt evaluator.
// Depends on nothing; every other file in hdl but pvp_div_pipe refers to it by scoped names.
package pvp_pkg;

  typedef struct packed {
    logic signed [31:0] sample_position;
    logic signed [31:0] sum_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] profile_value;
    logic signed [31:0] sum_out;
    logic signed [31:0] peak_area;
    logic               width_fault;
  } out_beat_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_CENTER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LORENTZ_FRACTION = 2'd3;

  localparam logic [31:0] RST_PEAK_CENTER      = 32'd0;
  localparam logic [31:0] RST_HALF_WIDTH       = 32'd65536;
  localparam logic [31:0] RST_PEAK_HEIGHT      = 32'd65536;
  localparam logic [16:0] RST_LORENTZ_FRACTION = 17'd32768;

  // Eta of one in Q1.16, and pi and sqrt(pi/ln2) in Q2.29.
  localparam logic [16:0] ETA_ONE  = 17'd65536;
  localparam logic [30:0] PI_Q29   = 31'd1686629713;
  localparam logic [30:0] SQPL_Q29 = 31'd1142962759;

  // Divider geometry: quotient bits retired per pipeline stage.
  localparam int DIV_STEPS = 2;
  localparam int GAUSS_BITS = 16;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    return m;
  endfunction

  // Signed saturation of a magnitude with a separate sign.
  function automatic logic [31:0] sat_mag(input logic [32:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      r = (mag >= 33'h0_8000_0000) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = 64'd0;
    b  = 64'h4000_0000_0000_0000;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factor 2^(-2^-k) in Q0.32, built by repeated square roots; used for constants only.
  function automatic logic [31:0] gauss_factor(input int k);
    logic [63:0] t;
    t = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 2; i <= k; i++) begin
      t = isqrt64({t[31:0], 32'd0});
    end
    return t[31:0];
  endfunction

endpackage

FILE: hdl/pvp_div_pipe.sv
// Pipelined restoring divider: a fixed number of quotient bits per register stage.
// Depends on pvp_pkg only through the parameters handed down from the top level.
module pvp_div_pipe #(
  parameter int DW  = 32,
  parameter int QW  = 32,
  parameter int SPS = 2,
  parameter int SW  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_low,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int NST = QW / SPS;

  logic [DW-1:0] rem_r  [NST];
  logic [DW-1:0] den_r  [NST];
  logic [QW-1:0] low_r  [NST];
  logic [QW-1:0] quo_r  [NST];
  logic [SW-1:0] side_r [NST];
  logic [NST-1:0] vld_r;

  for (genvar st = 0; st < NST; st++) begin : g_stage
    logic [DW-1:0] src_rem;
    logic [DW-1:0] src_den;
    logic [QW-1:0] src_low;
    logic [QW-1:0] src_quo;
    logic [SW-1:0] src_side;
    logic          src_vld;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] low_nxt;
    logic [QW-1:0] quo_nxt;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (st == 0) begin : g_first
      assign src_rem  = in_rem;
      assign src_den  = in_den;
      assign src_low  = in_low;
      assign src_quo  = '0;
      assign src_side = in_side;
      assign src_vld  = in_valid;
    end else begin : g_next
      assign src_rem  = rem_r[st-1];
      assign src_den  = den_r[st-1];
      assign src_low  = low_r[st-1];
      assign src_quo  = quo_r[st-1];
      assign src_side = side_r[st-1];
      assign src_vld  = vld_r[st-1];
    end

    always_comb begin
      rem_nxt = src_rem;
      low_nxt = src_low;
      quo_nxt = src_quo;
      trial   = '0;
      diff    = '0;
      for (int j = 0; j < SPS; j++) begin
        trial   = {rem_nxt, low_nxt[QW-1]};
        low_nxt = {low_nxt[QW-2:0], 1'b0};
        diff    = trial - {1'b0, src_den};
        if (trial >= {1'b0, src_den}) begin
          rem_nxt = diff[DW-1:0];
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else if (adv) begin
        vld_r[st] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[st]  <= rem_nxt;
        den_r[st]  <= src_den;
        low_r[st]  <= low_nxt;
        quo_r[st]  <= quo_nxt;
        side_r[st] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quo   = quo_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

FILE: hdl/pvp_gauss_pipe.sv
// Gaussian term 2^(-u^2) in Q1.32: one conditional constant multiply per stage, then a shift.
// Depends on pvp_pkg for the factor table and the fraction bit count.
module pvp_gauss_pipe (
  input  logic        clk,
  input  logic        adv,
  input  logic [47:0] in_usq_hi,
  output logic [32:0] out_gauss
);

  localparam int NB = pvp_pkg::GAUSS_BITS;

  logic [32:0] g_r   [NB];
  logic [15:0] f_r   [NB];
  logic        big_r [NB];
  logic [4:0]  sh_r  [NB];
  logic [32:0] out_r;

  for (genvar st = 0; st < NB; st++) begin : g_stage
    localparam logic [31:0] TK = pvp_pkg::gauss_factor(st + 1);
    logic [32:0] src_g;
    logic [15:0] src_f;
    logic        src_big;
    logic [4:0]  src_sh;
    logic [64:0] prod;

    if (st == 0) begin : g_first
      assign src_g   = 33'h1_0000_0000;
      assign src_f   = in_usq_hi[15:0];
      assign src_big = |in_usq_hi[47:21];
      assign src_sh  = in_usq_hi[20:16];
    end else begin : g_next
      assign src_g   = g_r[st-1];
      assign src_f   = f_r[st-1];
      assign src_big = big_r[st-1];
      assign src_sh  = sh_r[st-1];
    end

    assign prod = {32'd0, src_g} * {33'd0, TK};

    always_ff @(posedge clk) begin
      if (adv) begin
        g_r[st]   <= src_f[15] ? prod[64:32] : src_g;
        f_r[st]   <= {src_f[14:0], 1'b0};
        big_r[st] <= src_big;
        sh_r[st]  <= src_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= big_r[NB-1] ? 33'd0 : (g_r[NB-1] >> sh_r[NB-1]);
    end
  end

  assign out_gauss = out_r;

endmodule

FILE: hdl/pvp_area_calc.sv
// Peak area from the configuration registers, four register stages, free running.
// Depends on pvp_pkg for pi constants and the saturation helper.
module pvp_area_calc (
  input  logic        clk,
  input  logic [16:0] eta,
  input  logic [31:0] ah,
  input  logic [31:0] ai,
  input  logic        neg,
  output logic [31:0] area
);

  logic [47:0] mpi_r;
  logic [47:0] mk_r;
  logic [46:0] p_r;
  logic [30:0] m_r;
  logic [29:0] pl_r;
  logic        big_r;
  logic        big2_r;
  logic [60:0] prod_r;
  logic [31:0] area_r;
  logic [16:0] geta;
  logic [63:0] aiah;
  logic [48:0] msum;
  logic [60:0] rnd;

  assign geta = pvp_pkg::ETA_ONE - eta;
  assign aiah = {32'd0, ai} * {32'd0, ah};
  assign msum = {1'b0, mpi_r} + {1'b0, mk_r};
  assign rnd  = prod_r + 61'h0_1000_0000;

  always_ff @(posedge clk) begin
    mpi_r  <= {31'd0, eta} * {17'd0, pvp_pkg::PI_Q29};
    mk_r   <= {31'd0, geta} * {17'd0, pvp_pkg::SQPL_Q29};
    p_r    <= aiah[62:16];
    m_r    <= msum[46:16];
    pl_r   <= p_r[29:0];
    big_r  <= |p_r[46:30];
    prod_r <= {31'd0, pl_r} * {30'd0, m_r};
    big2_r <= big_r;
    area_r <= big2_r ? pvp_pkg::sat_mag(33'h0_8000_0000, neg)
                     : pvp_pkg::sat_mag({1'b0, rnd[60:29]}, neg);
  end

  assign area = area_r;

endmodule

FILE: hdl/pseudo_voigt_profile_eval_top.sv
// Top level of the pseudo-Voigt peak evaluator: registers, pipeline glue and output stage.
// Depends on pvp_pkg, pvp_div_pipe, pvp_gauss_pipe and pvp_area_calc.
//
// Usage: each input beat carries a sample position and the running sum at that sample.
// The block returns one output beat per input beat, in order: the profile value, the
// updated running sum, the peak area and a width fault flag. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the peak center, half width, height
// and Lorentz fraction; cfg_ready is always high, and writes are expected only while no
// beat is in flight. The area follows a register write through the derived registers
// and the register stages of pvp_area_calc. Throughput is one beat per cycle while the
// receiver does not stall; the pipeline depth is set by the two 2-bit-per-stage dividers
// (the u divider of 16 stages and the Lorentz reciprocal of 17 stages) and the
// multiplier stages around them.
// Reset (synchronous, active low) loads the register defaults and clears every valid bit,
// so no stale beat can emerge. When the receiver stalls while a result is waiting, the
// whole pipeline holds and in_stall rises in the same cycle; nothing is lost or repeated,
// and an input beat is taken in the very cycle that the waiting result is taken.
module pseudo_voigt_profile_eval_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pvp_pkg::in_beat_t                   in_beat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pvp_pkg::out_beat_t                  out_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pvp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data
);

  // Configuration registers and values derived from them.
  logic [31:0] center_r;
  logic [31:0] width_r;
  logic [31:0] height_r;
  logic [16:0] eta_r;
  logic [31:0] ah_r;
  logic [31:0] ai_r;
  logic        neg_r;
  logic        fault_r;
  logic [16:0] eta_c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= pvp_pkg::RST_PEAK_CENTER;
      width_r  <= pvp_pkg::RST_HALF_WIDTH;
      height_r <= pvp_pkg::RST_PEAK_HEIGHT;
      eta_r    <= pvp_pkg::RST_LORENTZ_FRACTION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pvp_pkg::REG_PEAK_CENTER:      center_r <= cfg_data;
        pvp_pkg::REG_HALF_WIDTH:       width_r  <= cfg_data;
        pvp_pkg::REG_PEAK_HEIGHT:      height_r <= cfg_data;
        pvp_pkg::REG_LORENTZ_FRACTION: eta_r    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Derived values settle the cycle after a write; users keep the block idle, unchecked.
  always_ff @(posedge clk) begin
    ah_r    <= pvp_pkg::mag32(width_r);
    ai_r    <= pvp_pkg::mag32(height_r);
    neg_r   <= height_r[31];
    fault_r <= (width_r == 32'd0);
    eta_c_r <= (eta_r > pvp_pkg::ETA_ONE) ? pvp_pkg::ETA_ONE : eta_r;
  end

  // The whole pipeline moves unless a finished result waits on a stalled receiver.
  logic adv;
  logic out_valid_r;
  pvp_pkg::out_beat_t out_beat_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 0: distance from the peak center.
  logic [32:0] diff;
  logic [32:0] ad_nxt;
  logic [32:0] ad0_r;
  logic [31:0] sin0_r;
  logic        v0_r;

  assign diff   = {in_beat.sample_position[31], in_beat.sample_position}
                - {center_r[31], center_r};
  assign ad_nxt = diff[32] ? (33'd0 - diff) : diff;

  always_ff @(posedge clk) begin
    if (adv) begin
      ad0_r  <= ad_nxt;
      sin0_r <= in_beat.sum_in;
    end
  end

  // |u| = |x - c| * 2^16 / |hwhm|; when the quotient does not fit in 32 bits it clamps.
  logic        ovf;
  logic        v1;
  logic [31:0] q1;
  logic [32:0] side1;

  assign ovf = ({15'd0, ad0_r[32:16]} >= ah_r);

  pvp_div_pipe #(
    .DW  (32),
    .QW  (32),
    .SPS (pvp_pkg::DIV_STEPS),
    .SW  (33)
  ) u_div_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v0_r),
    .in_rem    ({15'd0, ad0_r[32:16]}),
    .in_den    (ah_r),
    .in_low    ({ad0_r[15:0], 16'd0}),
    .in_side   ({ovf, sin0_r}),
    .out_valid (v1),
    .out_quo   (q1),
    .out_side  (side1)
  );

  // u^2 in Q32.32.
  logic [31:0] au;
  logic [63:0] usq_nxt;
  logic [63:0] usq_r;
  logic [31:0] sin2_r;
  logic        v2_r;

  assign au      = side1[32] ? 32'hFFFF_FFFF : q1;
  assign usq_nxt = {32'd0, au} * {32'd0, au};

  always_ff @(posedge clk) begin
    if (adv) begin
      usq_r  <= usq_nxt;
      sin2_r <= side1[31:0];
    end
  end

  // Lorentz term 2^64 / (2^32 + u^2) and the Gaussian term run side by side, 17 stages each.
  logic        v3;
  logic [33:0] lq;
  logic [31:0] sin3;
  logic [32:0] g3;

  pvp_div_pipe #(
    .DW  (64),
    .QW  (34),
    .SPS (pvp_pkg::DIV_STEPS),
    .SW  (32)
  ) u_div_lor (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v2_r),
    .in_rem    (64'h0000_0000_4000_0000),
    .in_den    (64'h0000_0001_0000_0000 + usq_r),
    .in_low    (34'd0),
    .in_side   (sin2_r),
    .out_valid (v3),
    .out_quo   (lq),
    .out_side  (sin3)
  );

  pvp_gauss_pipe u_gauss (
    .clk       (clk),
    .adv       (adv),
    .in_usq_hi (usq_r[63:16]),
    .out_gauss (g3)
  );

  // Mixing: the two weighted products, then their sum in Q1.32.
  logic [16:0] geta;
  logic [49:0] prodg_r;
  logic [49:0] prodl_r;
  logic [31:0] sin4_r;
  logic        v4_r;
  logic [50:0] ssum;
  logic [32:0] s_r;
  logic [31:0] sin5_r;
  logic        v5_r;

  assign geta = pvp_pkg::ETA_ONE - eta_c_r;
  assign ssum = {1'b0, prodg_r} + {1'b0, prodl_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      prodg_r <= {33'd0, geta} * {17'd0, g3};
      prodl_r <= {33'd0, eta_c_r} * {17'd0, lq[32:0]};
      sin4_r  <= sin3;
      s_r     <= ssum[48:16];
      sin5_r  <= sin4_r;
    end
  end

  // Scaling by the peak height, rounded to nearest and saturated.
  logic [64:0] ph_r;
  logic [31:0] sin6_r;
  logic        v6_r;
  logic [64:0] ph_rnd;
  logic [31:0] prof_r;
  logic [31:0] sin7_r;
  logic        v7_r;

  assign ph_rnd = ph_r + 65'h0_8000_0000;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r   <= {33'd0, ai_r} * {32'd0, s_r};
      sin6_r <= sin5_r;
      prof_r <= pvp_pkg::sat_mag(ph_rnd[64:32], neg_r);
      sin7_r <= sin6_r;
    end
  end

  // Peak area comes from the configuration alone.
  logic [31:0] area_w;

  pvp_area_calc u_area (
    .clk  (clk),
    .eta  (eta_c_r),
    .ah   (ah_r),
    .ai   (ai_r),
    .neg  (neg_r),
    .area (area_w)
  );

  // Output stage: running sum with saturation, fault override.
  logic [32:0] sum33;
  logic [31:0] sum_sat;
  pvp_pkg::out_beat_t out_beat_nxt;

  assign sum33 = {sin7_r[31], sin7_r} + {prof_r[31], prof_r};

  always_comb begin
    if (sum33[32] != sum33[31]) begin
      sum_sat = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sum_sat = sum33[31:0];
    end
    out_beat_nxt.profile_value = fault_r ? 32'sd0 : prof_r;
    out_beat_nxt.sum_out       = fault_r ? sin7_r : sum_sat;
    out_beat_nxt.peak_area     = area_w;
    out_beat_nxt.width_fault   = fault_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  // Valid bits of the stages kept in this module.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v2_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      v2_r        <= v1;
      v4_r        <= v3;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // The input side is held back only by a result waiting on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A zero half width forces a zero profile.
  a_fault_profile: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.width_fault) |-> (out_beat_r.profile_value == 32'sd0))
    else $error("fault beat carries a nonzero profile");

  // A zero half width gives a zero area.
  a_fault_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.width_fault) |-> (out_beat_r.peak_area == 32'sd0))
    else $error("fault beat carries a nonzero area");

  // A non-negative height never yields a negative profile.
  a_profile_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !height_r[31]) |-> !out_beat_r.profile_value[31])
    else $error("profile sign disagrees with height");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for pseudo_voigt_profile_eval_top: drives sample beats in bursts,
// stalls the result side, and checks every result beat against a bit-exact profile predictor.
// Depends on pvp_pkg for the beat structs and the register index codes.
module testbench;
  import pvp_pkg::*;

  // Holds the expected result beats and the predictor state, which is the register file.
  class pv_scoreboard;
    logic [31:0] center_q, width_q, height_q;
    logic [16:0] eta_q;
    logic [31:0] gauss_step[1:16];
    out_beat_t   expected_q[$];
    int          errors;

    function new();
      logic [63:0] t;
      t = root64(64'h8000_0000_0000_0000);
      for (int k = 1; k <= 16; k++) begin
        gauss_step[k] = t[31:0];
        t = root64(t << 32);
      end
      center_q = RST_PEAK_CENTER;
      width_q  = RST_HALF_WIDTH;
      height_q = RST_PEAK_HEIGHT;
      eta_q    = RST_LORENTZ_FRACTION;
      errors   = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_PEAK_CENTER:      center_q = data;
        REG_HALF_WIDTH:       width_q  = data;
        REG_PEAK_HEIGHT:      height_q = data;
        REG_LORENTZ_FRACTION: eta_q    = data[16:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_mag(logic [63:0] mag, logic neg);
      if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      return (mag >= 64'h8000_0000) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function out_beat_t evaluate(in_beat_t b);
      out_beat_t   r;
      longint      xs, cs, hs, is, diff, total;
      logic [63:0] ah, ai, ad, au, usq, g, lor, shape, pm, mix, prod, eta;
      logic [127:0] quot;
      logic        neg;
      xs  = longint'(b.sample_position);
      cs  = longint'($signed(center_q));
      hs  = longint'($signed(width_q));
      is  = longint'($signed(height_q));
      ah  = (hs < 0) ? -hs : hs;
      ai  = (is < 0) ? -is : is;
      neg = is < 0;
      eta = (eta_q > ETA_ONE) ? 64'd65536 : 64'(eta_q);
      r.profile_value = 0;
      r.sum_out       = b.sum_in;
      r.width_fault   = 1'b1;
      if (ah != 0) begin
        r.width_fault = 1'b0;
        diff = xs - cs;
        ad   = (diff < 0) ? -diff : diff;
        au   = (ad << 16) / ah;
        if (au > 64'hFFFF_FFFF) au = 64'hFFFF_FFFF;
        usq = au * au;
        // Gaussian 2^-u^2: fraction bits pick factors, the integer part shifts.
        if ((usq >> 32) >= 32) begin
          g = 0;
        end else begin
          g = 64'h1_0000_0000;
          for (int k = 1; k <= 16; k++)
            if (usq[32-k]) g = (g * gauss_step[k]) >> 32;
          g = g >> (usq >> 32);
        end
        quot  = (128'd1 << 64) / (128'h1_0000_0000 + 128'(usq));
        lor   = quot[63:0];
        shape = ((64'd65536 - eta) * g + eta * lor) >> 16;
        pm    = (ai * shape + 64'h8000_0000) >> 32;
        r.profile_value = clamp_mag(pm, neg);
        total = longint'(b.sum_in) + longint'(r.profile_value);
        if (total > 64'sd2147483647) r.sum_out = 32'h7FFF_FFFF;
        else if (total < -64'sd2147483648) r.sum_out = 32'h8000_0000;
        else r.sum_out = total[31:0];
      end
      mix  = (eta * 64'(PI_Q29) + (64'd65536 - eta) * 64'(SQPL_Q29)) >> 16;
      prod = (ai * ah) >> 16;
      if (prod >= 64'h4000_0000) r.peak_area = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else r.peak_area = clamp_mag((prod * mix + 64'h1000_0000) >> 29, neg);
      return r;
    endfunction

    function void note_input(in_beat_t b);
      expected_q.push_back(evaluate(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      if (got.profile_value !== want.profile_value)
        report($sformatf("profile %h, expected %h", got.profile_value, want.profile_value));
      if (got.sum_out !== want.sum_out)
        report($sformatf("sum %h, expected %h", got.sum_out, want.sum_out));
      if (got.peak_area !== want.peak_area)
        report($sformatf("area %h, expected %h", got.peak_area, want.peak_area));
      if (got.width_fault !== want.width_fault)
        report($sformatf("fault %b, expected %b", got.width_fault, want.width_fault));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_beat = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_beat;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PEAK_CENTER;
  logic [31:0] cfg_data = '0;

  pv_scoreboard profile_sb = new();
  int          stall_mode = 0;

  pseudo_voigt_profile_eval_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Both handshakes are observed at the rising edge, where the block's outputs still
  // hold the values they had through the cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) profile_sb.note_input(in_beat);
      if (out_valid && !out_stall) profile_sb.check_result(out_beat);
    end
  end

  // At random moments the receiver changes character: no stalls, light random stalls,
  // or heavy random back pressure.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Presents one sample beat and holds it until the block takes it.
  task automatic send_sample(in_beat_t b);
    @(negedge clk);
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Registers are written only with nothing in flight: the task waits until every
  // expected result has come back before it returns.
  task automatic drain();
    while (profile_sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    profile_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_peak(logic [31:0] c, logic [31:0] w, logic [31:0] h, logic [31:0] e);
    drain();
    write_reg(REG_PEAK_CENTER, c);
    write_reg(REG_HALF_WIDTH, w);
    write_reg(REG_PEAK_HEIGHT, h);
    write_reg(REG_LORENTZ_FRACTION, e);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 262143);
      3: return -$urandom_range(0, 262143);
      default: return $urandom;
    endcase
  endfunction

  // Most samples land within a few half widths of the peak, where the Gaussian and
  // Lorentzian terms both matter; the rest are anywhere on the axis.
  function automatic in_beat_t make_sample();
    in_beat_t    b;
    logic [31:0] span;
    span = profile_sb.width_q[31] ? -profile_sb.width_q : profile_sb.width_q;
    if (span == 0 || span > 32'h0100_0000) span = 32'h0001_0000;
    if ($urandom_range(0, 3) != 0)
      b.sample_position = profile_sb.center_q + ($urandom % (span * 12 + 1)) - span * 6;
    else
      b.sample_position = $urandom;
    b.sum_in = ($urandom_range(0, 4) == 0) ? pick_word() : $urandom_range(0, 1 << 20) - (1 << 19);
    return b;
  endfunction

  // Random samples in bursts with random gaps between them; some bursts run back to back.
  task automatic random_samples(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--) send_sample(make_sample());
      if ($urandom_range(0, 2) != 0) begin
        pause_sender();
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    pause_sender();
  endtask

  task automatic directed_samples();
    logic [31:0] pos[9];
    in_beat_t    b;
    pos = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
            32'h0000_8000, 32'h0000_0001, 32'h0020_0000, 32'hFFE0_0000};
    foreach (pos[i]) begin
      b.sample_position = pos[i];
      b.sum_in = (i % 3 == 0) ? 32'h7FFF_FFFF : (i % 3 == 1) ? 32'h8000_0000 : 32'h0;
      send_sample(b);
    end
    pause_sender();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults first, then the edges of the register ranges: zero and negative
    // widths, the height extremes, and eta at zero, one and above one.
    directed_samples();
    load_peak(32'h0, 32'h0, 32'h0001_0000, 32'd32768);
    directed_samples();
    load_peak(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    directed_samples();
    load_peak(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'd65536);
    directed_samples();
    load_peak(32'h7FFF_FFFF, 32'hFFFF_0000, 32'hFFF0_0000, 32'h0001_FFFF);
    directed_samples();

    load_peak(32'h0, 32'h0001_0000, 32'h0001_0000, 32'd32768);
    random_samples(200);
    for (int phase = 0; phase < 8; phase++) begin
      load_peak(pick_word(), (phase == 3) ? 32'h0 : pick_word(), pick_word(),
                (phase % 4 == 0) ? 32'd65536 : (phase % 4 == 1) ? 32'd0 :
                (phase % 4 == 2) ? $urandom_range(65537, 131071) : $urandom_range(0, 65536));
      random_samples(200);
    end

    drain();
    if (profile_sb.expected_q.size() != 0) profile_sb.report("expected results never came");
    if (profile_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Generous ceiling on the whole run; a hang ends here as a failure.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end
endmodule
